FILE: src/lkvc_pkg.sv
`default_nettype none
package lkvc_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int KEY_BITS    = 16;
  localparam int VALUE_BITS  = 16;
  localparam int CFG_BITS    = 5;
  localparam int IDX_BITS    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1);

  localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(16);

  typedef enum logic {
    ACT_GET = 1'b0,
    ACT_PUT = 1'b1
  } action_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic load_req;
    logic commit;
  } lkvc_cmd_t;

  typedef struct packed {
    logic out_blocked;
  } lkvc_status_t;

endpackage
`default_nettype wire

FILE: src/lru_key_value_cache_core.sv
`default_nettype none
// Fully associative key/value cache with least-recently-used replacement.
// Request channel: req_valid/req_stall with action (0 get, 1 put), key, value.
// Response channel: rsp_valid/rsp_stall with found and read_value; exactly one
// response per request, in request order. read_value is the stored value on a
// get hit and zero otherwise.
// A request is accepted in the idle state; the execute state then compares the
// key against all entries in parallel, updates the recency ranks and store, and
// loads the response register. The block returns to idle only after that, so it
// takes no new request until the previous one has been committed; all entries
// are compared and re-ranked in the single execute state.
// When the receiver stalls a held response, the block finishes the next
// request only up to the execute state and waits there with req_stall high.
// The capacity register (cfg_write/cfg_data) is to be written while idle, which
// the block does not enforce; zero acts as one and values above 16 act as 16.
// Synchronous reset empties the store, drops any response and sets the
// capacity to 16; the block takes requests in the cycle after reset.
module lru_key_value_cache_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [lkvc_pkg::CFG_BITS-1:0]       cfg_data,
  input  wire logic                                req_valid,
  output logic                                     req_stall,
  input  wire logic                                action,
  input  wire logic [lkvc_pkg::KEY_BITS-1:0]       key,
  input  wire logic [lkvc_pkg::VALUE_BITS-1:0]     value,
  output logic                                     rsp_valid,
  input  wire logic                                rsp_stall,
  output logic                                     found,
  output logic [lkvc_pkg::VALUE_BITS-1:0]          read_value
);

  lkvc_pkg::lkvc_cmd_t    cmd;
  lkvc_pkg::lkvc_status_t status;

  lkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  lkvc_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .action     (action),
    .key        (key),
    .value      (value),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .found      (found),
    .read_value (read_value),
    .cmd        (cmd),
    .status     (status)
  );

endmodule
`default_nettype wire

FILE: src/lkvc_ctrl.sv
`default_nettype none
module lkvc_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  req_valid,
  output logic                       req_stall,
  input  wire lkvc_pkg::lkvc_status_t status,
  output lkvc_pkg::lkvc_cmd_t        cmd
);

  lkvc_pkg::state_t state;
  lkvc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lkvc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    req_stall    = 1'b1;
    cmd.load_req = 1'b0;
    cmd.commit   = 1'b0;
    case (state)
      lkvc_pkg::ST_IDLE: begin
        if (!rst) begin
          req_stall = 1'b0;
          if (req_valid) begin
            cmd.load_req = 1'b1;
            state_next   = lkvc_pkg::ST_EXEC;
          end
        end
      end
      lkvc_pkg::ST_EXEC: begin
        // hold until the response register can take the result
        if (!status.out_blocked) begin
          cmd.commit = 1'b1;
          state_next = lkvc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lkvc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: src/lkvc_datapath.sv
`default_nettype none
module lkvc_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write,
  input  wire logic [lkvc_pkg::CFG_BITS-1:0]         cfg_data,
  input  wire logic                                  action,
  input  wire logic [lkvc_pkg::KEY_BITS-1:0]         key,
  input  wire logic [lkvc_pkg::VALUE_BITS-1:0]       value,
  output logic                                       rsp_valid,
  input  wire logic                                  rsp_stall,
  output logic                                       found,
  output logic [lkvc_pkg::VALUE_BITS-1:0]            read_value,
  input  wire lkvc_pkg::lkvc_cmd_t                   cmd,
  output lkvc_pkg::lkvc_status_t                     status
);

  localparam int N  = lkvc_pkg::MAX_ENTRIES;
  localparam int IW = lkvc_pkg::IDX_BITS;
  localparam int CW = lkvc_pkg::CNT_BITS;
  localparam int KW = lkvc_pkg::KEY_BITS;
  localparam int VW = lkvc_pkg::VALUE_BITS;

  logic [lkvc_pkg::CFG_BITS-1:0] entries_in_use;

  logic          req_put;
  logic [KW-1:0] req_key;
  logic [VW-1:0] req_value;

  logic [N-1:0]  entry_valid;
  logic [N-1:0]  entry_valid_next;
  logic [KW-1:0] entry_key   [N];
  logic [VW-1:0] entry_value [N];
  logic [IW-1:0] recency_rank [N];
  logic [IW-1:0] recency_rank_next [N];
  logic [CW-1:0] valid_count;

  logic [CW-1:0] capacity;
  logic [CW-1:0] count_m1;
  logic [IW-1:0] last_rank;
  logic [N-1:0]  match;
  logic          hit;
  logic [IW-1:0] hit_idx;
  logic [IW-1:0] hit_rank;
  logic [VW-1:0] hit_value;
  logic          evict;
  logic [N-1:0]  valid_after;
  logic [IW-1:0] free_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= lkvc_pkg::CFG_RESET;
    end else if (cfg_write) begin
      entries_in_use <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_put   <= (action == lkvc_pkg::ACT_PUT);
      req_key   <= key;
      req_value <= value;
    end
  end

  always_comb begin
    if (entries_in_use == '0) begin
      capacity = CW'(1);
    end else if (32'(entries_in_use) > N) begin
      capacity = CW'(N);
    end else begin
      capacity = CW'(entries_in_use);
    end
  end

  assign count_m1  = valid_count - CW'(1);
  assign last_rank = count_m1[IW-1:0];

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < N; i++) begin
      match[i] = entry_valid[i] && (entry_key[i] == req_key);
      if (match[i]) begin
        hit_idx = hit_idx | IW'(i);
      end
    end
  end

  assign hit       = |match;
  assign hit_rank  = recency_rank[hit_idx];
  assign hit_value = entry_value[hit_idx];
  assign evict     = req_put && !hit && (valid_count >= capacity);

  always_comb begin
    free_idx = '0;
    for (int i = 0; i < N; i++) begin
      valid_after[i] = entry_valid[i] &&
                       !(evict && (recency_rank[i] == last_rank));
    end
    for (int i = N - 1; i >= 0; i--) begin
      if (!valid_after[i]) begin
        free_idx = IW'(i);
      end
    end
    entry_valid_next           = valid_after;
    entry_valid_next[free_idx] = 1'b1;
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      recency_rank_next[i] = recency_rank[i];
      if (hit) begin
        if (IW'(i) == hit_idx) begin
          recency_rank_next[i] = '0;
        end else if (entry_valid[i] && (recency_rank[i] < hit_rank)) begin
          recency_rank_next[i] = recency_rank[i] + IW'(1);
        end
      end else if (req_put) begin
        if (IW'(i) == free_idx) begin
          recency_rank_next[i] = '0;
        end else if (valid_after[i]) begin
          recency_rank_next[i] = recency_rank[i] + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      valid_count <= '0;
    end else if (cmd.commit && req_put && !hit) begin
      entry_valid <= entry_valid_next;
      if (!evict) begin
        valid_count <= valid_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < N; i++) begin
        recency_rank[i] <= recency_rank_next[i];
      end
      if (hit) begin
        if (req_put) begin
          entry_value[hit_idx] <= req_value;
        end
      end else if (req_put) begin
        entry_key[free_idx]   <= req_key;
        entry_value[free_idx] <= req_value;
      end
    end
  end

  assign status.out_blocked = rsp_valid && rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      found      <= hit;
      read_value <= (hit && !req_put) ? hit_value : '0;
    end
  end

endmodule
`default_nettype wire

FILE: src/lkvc_checker.sv
`default_nettype none
module lkvc_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              req_valid,
  input wire logic                              req_stall,
  input wire logic                              rsp_valid,
  input wire logic                              rsp_stall,
  input wire logic                              found,
  input wire logic [lkvc_pkg::VALUE_BITS-1:0]   read_value
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(found) && $stable(read_value))
    else $error("stalled response changed");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted while another is in progress");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !found |-> read_value == '0)
    else $error("read_value nonzero on a miss");

  a_rsp_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("response produced without a request in progress");

endmodule

bind lru_key_value_cache_core lkvc_checker u_lkvc_checker (.*);
`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import lkvc_pkg::*;

  typedef struct {
    logic                  hit;
    logic [VALUE_BITS-1:0] data;
  } lookup_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_BITS-1:0]   cfg_data;
  logic                  req_valid;
  logic                  req_stall;
  logic                  action;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value;
  logic                  rsp_valid;
  logic                  rsp_stall;
  logic                  found;
  logic [VALUE_BITS-1:0] read_value;

  lru_key_value_cache_core u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .action     (action),
    .key        (key),
    .value      (value),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .found      (found),
    .read_value (read_value)
  );

  // shadow copy of the cache contents
  logic                  slot_used [MAX_ENTRIES];
  logic [KEY_BITS-1:0]   slot_key  [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] slot_val  [MAX_ENTRIES];
  int                    slot_age  [MAX_ENTRIES];
  int                    used_count;
  int                    capacity;

  lookup_t lookup_q[$];

  bit sender_gaps;
  bit receiver_stalls;
  bit hold_toggle;
  int hold_len;
  int mismatches;
  int n_sent;
  int n_checked;
  int n_hits;
  int n_cfg;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic void cache_access(input action_t act, input logic [KEY_BITS-1:0] k,
                                       input logic [VALUE_BITS-1:0] v,
                                       output logic hit, output logic [VALUE_BITS-1:0] rd);
    int slot;
    int victim;
    int old_age;
    slot = -1;
    for (int i = 0; i < MAX_ENTRIES; i++)
      if (slot < 0 && slot_used[i] && slot_key[i] == k) slot = i;
    hit = (slot >= 0);
    rd  = '0;
    if (slot >= 0) begin
      old_age = slot_age[slot];
      for (int i = 0; i < MAX_ENTRIES; i++)
        if (slot_used[i] && slot_age[i] < old_age) slot_age[i]++;
      slot_age[slot] = 0;
      if (act == ACT_GET) rd = slot_val[slot];
      else slot_val[slot] = v;
      return;
    end
    if (act == ACT_GET) return;
    if (used_count >= capacity) begin
      victim = -1;
      for (int i = 0; i < MAX_ENTRIES; i++)
        if (slot_used[i] && (victim < 0 || slot_age[i] > slot_age[victim])) victim = i;
      if (victim >= 0) begin
        slot_used[victim] = 1'b0;
        used_count--;
      end
    end
    for (int i = 0; i < MAX_ENTRIES; i++)
      if (slot < 0 && !slot_used[i]) slot = i;
    if (slot < 0) return;
    for (int i = 0; i < MAX_ENTRIES; i++)
      if (slot_used[i]) slot_age[i]++;
    slot_used[slot] = 1'b1;
    slot_key[slot]  = k;
    slot_val[slot]  = v;
    slot_age[slot]  = 0;
    used_count++;
  endfunction

  task automatic send_request(input action_t act, input logic [KEY_BITS-1:0] k,
                              input logic [VALUE_BITS-1:0] v);
    int gap;
    lookup_t exp_rsp;
    gap = sender_gaps ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    action    <= act;
    key       <= k;
    value     <= v;
    do @(posedge clk); while (req_stall);
    cache_access(act, k, v, exp_rsp.hit, exp_rsp.data);
    lookup_q.push_back(exp_rsp);
    n_sent++;
  endtask

  task automatic wait_drained();
    int spins;
    req_valid <= 1'b0;
    spins = 0;
    while (lookup_q.size() != 0) begin
      @(posedge clk);
      spins++;
      if (spins > 5000) begin
        $display("Test completed with failures");
        $finish;
      end
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CFG_BITS-1:0] c);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_data  <= c;
    @(posedge clk);
    cfg_write <= 1'b0;
    capacity = (c < 1) ? 1 : (c > MAX_ENTRIES) ? MAX_ENTRIES : int'(c);
    n_cfg++;
  endtask

  // check each accepted response against the oldest prediction
  initial begin : rsp_check
    int      wait_left;
    int      hold_left;
    bit      hold_seen;
    lookup_t exp_rsp;
    wait_left = 0;
    hold_left = 0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        n_checked++;
        if (lookup_q.size() == 0) begin
          $error("response with no request outstanding: found=%0b read_value=%h",
                 found, read_value);
          mismatches++;
        end else begin
          exp_rsp = lookup_q.pop_front();
          if (found !== exp_rsp.hit) begin
            $error("found: expected %0b, got %0b", exp_rsp.hit, found);
            mismatches++;
          end
          if (read_value !== exp_rsp.data) begin
            $error("read_value: expected %h, got %h", exp_rsp.data, read_value);
            mismatches++;
          end
          if (exp_rsp.hit) n_hits++;
        end
        wait_left = receiver_stalls ? $urandom_range(0, 5) : 0;
      end else if (wait_left > 0) begin
        wait_left--;
      end
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = hold_len;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      rsp_stall <= (wait_left > 0) || (hold_left > 0);
    end
  end

  task automatic test_directed();
    send_request(ACT_GET, 16'h0000, 16'h9999);
    send_request(ACT_PUT, 16'h0000, 16'hFFFF);
    send_request(ACT_PUT, 16'hFFFF, 16'h0000);
    send_request(ACT_GET, 16'h0000, 16'h0000);
    send_request(ACT_GET, 16'hFFFF, 16'hFFFF);
    send_request(ACT_PUT, 16'h0000, 16'h1234);
    send_request(ACT_GET, 16'h0000, 16'h0000);
    send_request(ACT_GET, 16'h5555, 16'h0000);
    for (int i = 0; i < 14; i++)
      send_request(ACT_PUT, KEY_BITS'(16'h0100 + i), VALUE_BITS'(16'hA500 + i));
    send_request(ACT_GET, 16'hFFFF, 16'h0000);
    // store full: evict the oldest key
    send_request(ACT_PUT, 16'hAAAA, 16'h5A5A);
    send_request(ACT_GET, 16'h0000, 16'h0000);
    send_request(ACT_GET, 16'hFFFF, 16'h0000);
  endtask

  task automatic test_capacity_limits();
    set_capacity(5'd0);
    for (int i = 0; i < 3; i++)
      send_request(ACT_PUT, KEY_BITS'(16'h2000 + i),
                   VALUE_BITS'($urandom_range(0, 16'hFFFF)));
    for (int i = 0; i < 3; i++)
      send_request(ACT_GET, KEY_BITS'(16'h2000 + i), 16'h0000);
    send_request(ACT_PUT, 16'h2002, 16'h0F0F);
    send_request(ACT_GET, 16'h2002, 16'h0000);
    set_capacity(5'd31);
    for (int i = 0; i < 20; i++)
      send_request(ACT_PUT, KEY_BITS'(16'h3000 + i),
                   VALUE_BITS'($urandom_range(0, 16'hFFFF)));
    for (int i = 0; i < 20; i++)
      send_request(ACT_GET, KEY_BITS'(16'h3000 + i), 16'h0000);
    set_capacity(5'd17);
    for (int i = 0; i < 18; i++)
      send_request(ACT_PUT, KEY_BITS'(16'h3800 + i),
                   VALUE_BITS'($urandom_range(0, 16'hFFFF)));
    // shrink below the fill level
    set_capacity(5'd2);
    for (int i = 0; i < 3; i++)
      send_request(ACT_PUT, KEY_BITS'(16'h4000 + i),
                   VALUE_BITS'($urandom_range(0, 16'hFFFF)));
    for (int i = 0; i < 18; i++)
      send_request(ACT_GET, KEY_BITS'(16'h3800 + i), 16'h0000);
    for (int i = 0; i < 3; i++)
      send_request(ACT_GET, KEY_BITS'(16'h4000 + i), 16'h0000);
  endtask

  task automatic test_backpressure();
    set_capacity(5'd8);
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    hold_len    = 60;
    hold_toggle = ~hold_toggle;
    for (int i = 0; i < 14; i++)
      send_request(action_t'($urandom_range(0, 1)), KEY_BITS'(16'h6000 + (i % 6)),
                   VALUE_BITS'($urandom_range(0, 16'hFFFF)));
    wait_drained();
    for (int i = 0; i < 8; i++)
      send_request(ACT_GET, KEY_BITS'(16'h6000 + i), 16'h0000);
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  task automatic test_random();
    logic [KEY_BITS-1:0] key_pool[24];
    logic [KEY_BITS-1:0] k;
    logic [CFG_BITS-1:0] cap_list[8];
    logic [CFG_BITS-1:0] cap;
    int pool_size;
    cap_list = '{5'd1, 5'd16, 5'd2, 5'd31, 5'd4, 5'd0, 5'd8, 5'd17};
    for (int phase = 0; phase < 13; phase++) begin
      cap = (phase < 8) ? cap_list[phase] : CFG_BITS'($urandom_range(0, 31));
      set_capacity(cap);
      pool_size = capacity + int'($urandom_range(1, 8));
      for (int i = 0; i < pool_size; i++)
        key_pool[i] = KEY_BITS'($urandom_range(0, 16'hFFFF));
      sender_gaps     = $urandom_range(0, 3) != 0;
      receiver_stalls = $urandom_range(0, 3) != 0;
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 9) == 0) k = KEY_BITS'($urandom_range(0, 16'hFFFF));
        else k = key_pool[$urandom_range(0, pool_size - 1)];
        send_request(action_t'($urandom_range(0, 1)), k,
                     VALUE_BITS'($urandom_range(0, 16'hFFFF)));
        if ($urandom_range(0, 49) == 0) wait_drained();
        if ($urandom_range(0, 29) == 0) begin
          sender_gaps     = ~sender_gaps;
          receiver_stalls = $urandom_range(0, 1) != 0;
        end
      end
    end
  endtask

  initial begin
    rst         = 1'b1;
    cfg_write   = 1'b0;
    cfg_data    = '0;
    req_valid   = 1'b0;
    action      = 1'b0;
    key         = '0;
    value       = '0;
    rsp_stall   = 1'b0;
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    hold_toggle = 1'b0;
    hold_len    = 0;
    mismatches  = 0;
    n_sent      = 0;
    n_checked   = 0;
    n_hits      = 0;
    n_cfg       = 0;
    used_count  = 0;
    capacity    = int'(CFG_RESET);
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i]  = '0;
      slot_val[i]  = '0;
      slot_age[i]  = 0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_capacity_limits();
    test_backpressure();
    test_random();

    wait_drained();
    repeat (10) @(posedge clk);
    if (lookup_q.size() != 0) begin
      $error("%0d responses never arrived", lookup_q.size());
      mismatches++;
    end
    $display("Ran %0d requests, checked %0d responses (%0d hits) over %0d capacity writes,",
             n_sent, n_checked, n_hits, n_cfg);
    $display("with random gaps and stalls, a long response hold-off and full drains.");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
